FILE: rtl/fcsr_pkg.sv
// Package for the FSM coverage set recorder.
// Holds the transfer payload types and the scan engine state type.
// No dependencies; used by fcsr_front, fcsr_back and the top level.
package fcsr_pkg;

    // Fixed field widths of the transfer payloads.
    localparam int FIELD_W      = 8;
    localparam int STATE_CNT_W  = 5;
    localparam int TRANS_CNT_W  = 6;

    // Mode codes of an input item.
    localparam logic MODE_STATE = 1'b0;
    localparam logic MODE_TRANS = 1'b1;

    // One input item.
    typedef struct packed {
        logic               mode;
        logic [FIELD_W-1:0] state_value;
        logic [FIELD_W-1:0] from_state;
        logic [FIELD_W-1:0] to_state;
    } t_in;

    // One result item.
    typedef struct packed {
        logic                   was_present;
        logic                   stored;
        logic                   table_full;
        logic [STATE_CNT_W-1:0] state_entries;
        logic [TRANS_CNT_W-1:0] transition_entries;
    } t_out;

    // States of the back-end scan engine.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

FILE: rtl/fcsr_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Used for both coverage tables; no package dependency.
module fcsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/fcsr_front.sv
// Front end of the coverage recorder: accepts items, forms the search key
// and buffers jobs in a two-entry queue. Depends on fcsr_pkg.
module fcsr_front #(
    parameter int STATE_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  fcsr_pkg::t_in           i_in_data,
    output logic                    o_job_valid,
    input  logic                    i_job_ready,
    output logic                    o_job_mode,
    output logic [2*STATE_BITS-1:0] o_job_key
);

    localparam int KW = 2 * STATE_BITS;

    logic [31:0]         sv_ext;
    logic [31:0]         from_ext;
    logic [31:0]         to_ext;
    logic [KW-1:0]       key;

    logic                r_q_mode [2];
    logic [KW-1:0]       r_q_key  [2];
    logic                r_wp;
    logic                r_rp;
    logic [1:0]          r_cnt;
    logic                push;
    logic                pop;

    // Mask the offered values to the state width and build the key.
    always_comb begin
        sv_ext   = 32'(i_in_data.state_value);
        from_ext = 32'(i_in_data.from_state);
        to_ext   = 32'(i_in_data.to_state);
        if (i_in_data.mode == fcsr_pkg::MODE_TRANS) begin
            key = {from_ext[STATE_BITS-1:0], to_ext[STATE_BITS-1:0]};
        end else begin
            key = {{STATE_BITS{1'b0}}, sv_ext[STATE_BITS-1:0]};
        end
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign push        = i_in_valid && o_in_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign pop         = o_job_valid && i_job_ready;
    assign o_job_mode  = r_q_mode[r_rp];
    assign o_job_key   = r_q_key[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_mode[r_wp] <= i_in_data.mode;
            r_q_key[r_wp]  <= key;
        end
    end

    // Queue pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTH
    // Occupancy tracks the pointers: equal pointers mean empty or full.
    a_ptr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp == r_rp) == (r_cnt == 2'd0 || r_cnt == 2'd2))
        else $error("queue pointers and occupancy disagree");
`endif

endmodule

FILE: rtl/fcsr_back.sv
// Back end of the coverage recorder: scans the selected table one entry per
// cycle, appends absent keys if the table has room and holds the result
// in an output register. Depends on fcsr_pkg and fcsr_ram.
module fcsr_back #(
    parameter int STATE_BITS       = 8,
    parameter int STATE_SLOTS      = 16,
    parameter int TRANSITION_SLOTS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_job_valid,
    output logic                    o_job_ready,
    input  logic                    i_job_mode,
    input  logic [2*STATE_BITS-1:0] i_job_key,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output fcsr_pkg::t_out          o_out_data
);

    localparam int KW   = 2 * STATE_BITS;
    localparam int SAW  = STATE_SLOTS > 1 ? $clog2(STATE_SLOTS) : 1;
    localparam int TAW  = TRANSITION_SLOTS > 1 ? $clog2(TRANSITION_SLOTS) : 1;
    localparam int SFW  = $clog2(STATE_SLOTS + 1);
    localparam int TFW  = $clog2(TRANSITION_SLOTS + 1);
    localparam int MAXS = STATE_SLOTS > TRANSITION_SLOTS ? STATE_SLOTS : TRANSITION_SLOTS;
    localparam int IW   = $clog2(MAXS + 1);

    fcsr_pkg::t_state r_state, n_state;
    logic             r_mode, n_mode;
    logic [KW-1:0]    r_key, n_key;
    logic [IW-1:0]    r_idx, n_idx;
    logic             r_pend, n_pend;
    logic             r_last, n_last;
    logic             r_hit, n_hit;
    logic [SFW-1:0]   r_sfill, n_sfill;
    logic [TFW-1:0]   r_tfill, n_tfill;
    logic             r_out_vld, n_out_vld;
    fcsr_pkg::t_out   r_out, n_out;

    logic [IW-1:0]    fill_sel;
    logic [IW-1:0]    pop_fill;
    logic             full_sel;
    logic             issue;
    logic             match;
    logic             out_free;
    logic             s_we;
    logic             t_we;
    logic [STATE_BITS-1:0] s_rdata;
    logic [KW-1:0]    t_rdata;
    logic [31:0]      s_cnt_ext;
    logic [31:0]      t_cnt_ext;

    // Fill count and room of the table that the current job addresses.
    assign fill_sel = (r_mode == fcsr_pkg::MODE_TRANS) ? IW'(r_tfill) : IW'(r_sfill);
    assign pop_fill = (i_job_mode == fcsr_pkg::MODE_TRANS) ? IW'(r_tfill) : IW'(r_sfill);
    assign full_sel = (r_mode == fcsr_pkg::MODE_TRANS)
                    ? (r_tfill == TFW'(TRANSITION_SLOTS))
                    : (r_sfill == SFW'(STATE_SLOTS));
    assign issue    = (r_state == fcsr_pkg::S_SCAN) && (r_idx < fill_sel);
    assign match    = r_pend && ((r_mode == fcsr_pkg::MODE_TRANS)
                                 ? (t_rdata == r_key)
                                 : (s_rdata == r_key[STATE_BITS-1:0]));
    assign out_free = !r_out_vld || i_out_ready;

    assign o_job_ready = (r_state == fcsr_pkg::S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Table memories.
    fcsr_ram #(.WIDTH(STATE_BITS), .DEPTH(STATE_SLOTS)) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_sfill[SAW-1:0]),
        .i_wdata (r_key[STATE_BITS-1:0]),
        .i_re    (issue && (r_mode == fcsr_pkg::MODE_STATE)),
        .i_raddr (r_idx[SAW-1:0]),
        .o_rdata (s_rdata)
    );

    fcsr_ram #(.WIDTH(KW), .DEPTH(TRANSITION_SLOTS)) u_trans_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (r_tfill[TAW-1:0]),
        .i_wdata (r_key),
        .i_re    (issue && (r_mode == fcsr_pkg::MODE_TRANS)),
        .i_raddr (r_idx[TAW-1:0]),
        .o_rdata (t_rdata)
    );

    // Next state: take a job, scan its table, then append and report.
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_key     = r_key;
        n_idx     = r_idx;
        n_pend    = 1'b0;
        n_last    = 1'b0;
        n_hit     = r_hit;
        n_sfill   = r_sfill;
        n_tfill   = r_tfill;
        n_out_vld = r_out_vld && !i_out_ready;
        n_out     = r_out;
        s_we      = 1'b0;
        t_we      = 1'b0;
        s_cnt_ext = 32'd0;
        t_cnt_ext = 32'd0;
        case (r_state)
            fcsr_pkg::S_IDLE: begin
                if (i_job_valid) begin
                    n_mode  = i_job_mode;
                    n_key   = i_job_key;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_state = (pop_fill == '0) ? fcsr_pkg::S_DONE : fcsr_pkg::S_SCAN;
                end
            end
            fcsr_pkg::S_SCAN: begin
                if (issue) begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                    n_last = (r_idx + 1'b1 == fill_sel);
                end
                if (match) begin
                    n_hit   = 1'b1;
                    n_state = fcsr_pkg::S_DONE;
                end else if (r_pend && r_last) begin
                    n_state = fcsr_pkg::S_DONE;
                end
            end
            fcsr_pkg::S_DONE: begin
                if (out_free) begin
                    if (!r_hit && !full_sel) begin
                        if (r_mode == fcsr_pkg::MODE_TRANS) begin
                            t_we    = 1'b1;
                            n_tfill = r_tfill + 1'b1;
                        end else begin
                            s_we    = 1'b1;
                            n_sfill = r_sfill + 1'b1;
                        end
                    end
                    s_cnt_ext                = 32'(n_sfill);
                    t_cnt_ext                = 32'(n_tfill);
                    n_out.was_present        = r_hit;
                    n_out.stored             = !r_hit && !full_sel;
                    n_out.table_full         = !r_hit && full_sel;
                    n_out.state_entries      = s_cnt_ext[fcsr_pkg::STATE_CNT_W-1:0];
                    n_out.transition_entries = t_cnt_ext[fcsr_pkg::TRANS_CNT_W-1:0];
                    n_out_vld                = 1'b1;
                    n_state                  = fcsr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fcsr_pkg::S_IDLE;
            end
        endcase
    end

    // State register and control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fcsr_pkg::S_IDLE;
            r_pend    <= 1'b0;
            r_last    <= 1'b0;
            r_sfill   <= '0;
            r_tfill   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_last    <= n_last;
            r_sfill   <= n_sfill;
            r_tfill   <= n_tfill;
            r_out_vld <= n_out_vld;
        end
    end

    // Job and result payload registers.
    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_key  <= n_key;
        r_idx  <= n_idx;
        r_hit  <= n_hit;
        r_out  <= n_out;
    end

`ifndef SYNTH
    // Each result reports exactly one outcome.
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $onehot({r_out.was_present, r_out.stored, r_out.table_full}))
        else $error("result reports other than one outcome");

    // Fill counts stay within the table depths.
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sfill <= SFW'(STATE_SLOTS)) && (r_tfill <= TFW'(TRANSITION_SLOTS)))
        else $error("fill count beyond table depth");

    // The state fill count grows by at most one entry per cycle.
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 (r_sfill == $past(r_sfill) || r_sfill == $past(r_sfill) + 1'b1))
        else $error("state fill count jumped");

    // The scan never reads past the written part of a table.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fcsr_pkg::S_SCAN) |-> (r_idx <= fill_sel))
        else $error("scan index beyond fill count");
`endif

endmodule

FILE: rtl/fsm_coverage_set_recorder.sv
// Top level of the FSM coverage set recorder.
// Instantiates fcsr_front and fcsr_back; depends on fcsr_pkg.
//
// Records covered FSM states and (from, to) transitions in two deduplicating
// tables. Each transfer on the input channel offers one value; the block
// reports whether it was already recorded, appended, or dropped because its
// table was full, together with both entry counts. Items enter a two-entry
// queue and are then handled one at a time by a scan engine that reads one
// table entry per cycle from a RAM with a registered read port. The time an
// item occupies the engine grows with the entries of its table, and a hit
// ends the scan early. An output register holds each result, so the engine
// can take and scan the next item while a result waits to be taken; it
// holds that item's result until the register is free.
// Both tables start empty after reset; no clearing pass is needed.
module fsm_coverage_set_recorder #(
    parameter int STATE_BITS       = 8,
    parameter int STATE_SLOTS      = 16,
    parameter int TRANSITION_SLOTS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  fcsr_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output fcsr_pkg::t_out o_out_data
);

    logic                    job_valid;
    logic                    job_ready;
    logic                    job_mode;
    logic [2*STATE_BITS-1:0] job_key;

    // Intake, key forming and job queue.
    fcsr_front #(.STATE_BITS(STATE_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job_mode  (job_mode),
        .o_job_key   (job_key)
    );

    // Table scan, insert and result register.
    fcsr_back #(
        .STATE_BITS       (STATE_BITS),
        .STATE_SLOTS      (STATE_SLOTS),
        .TRANSITION_SLOTS (TRANSITION_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job_mode  (job_mode),
        .i_job_key   (job_key),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
